// ===== hdl/segmented_stack_set_top_assert.svh =====
// Assertion macros for the stack set top level.
// Each expands to one labeled concurrent assertion on i_clk, off during reset.
`ifndef SEGMENTED_STACK_SET_TOP_ASSERT_SVH
`define SEGMENTED_STACK_SET_TOP_ASSERT_SVH

// Same-cycle implication.
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sss_pkg.sv =====
package sss_pkg;

    // Operation codes
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_POP_AT = 2'd2;
    localparam logic [1:0] KIND_PEEK   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Capacity register
    localparam int unsigned    CFG_W     = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] push_value;
        logic [3:0]         stack_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic               all_empty;
        logic [4:0]         stacks_in_use;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_EXEC,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture request
        logic map;    // resolve slots, read fill count
        logic exec;   // commit update, read value
        logic emit;   // load output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/sss_ctrl.sv =====
module sss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sss_pkg::t_sts i_sts,
    output sss_pkg::t_cmd o_cmd
);

    sss_pkg::t_state r_state;
    sss_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sss_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sss_pkg::S_MAP;
            end
            sss_pkg::S_MAP: begin
                n_state = sss_pkg::S_EXEC;
            end
            sss_pkg::S_EXEC: begin
                n_state = sss_pkg::S_RESULT;
            end
            sss_pkg::S_RESULT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) n_state = sss_pkg::S_IDLE;
            end
            default: begin
                n_state = sss_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sss_pkg::S_MAP: begin
                o_cmd.map = 1'b1;
            end
            sss_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            sss_pkg::S_RESULT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/sss_dpath.sv =====
module sss_dpath #(
    parameter int unsigned MAX_STACKS  = 16,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sss_pkg::t_cmd                 i_cmd,
    output sss_pkg::t_sts                 o_sts,
    input  sss_pkg::t_in_item             i_in_data,
    input  logic                          i_cfg_valid,
    input  logic [sss_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sss_pkg::t_out_item            o_out_data
);

    localparam int unsigned SLOT_W = $clog2(MAX_STACKS);
    localparam int unsigned CNT_W  = $clog2(MAX_STACKS + 1);
    localparam int unsigned FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned POS_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned WORDS  = MAX_STACKS * STACK_DEPTH;
    localparam int unsigned ADDR_W = $clog2(WORDS);
    localparam int unsigned CAP_W  = (FILL_W > sss_pkg::CFG_W) ? FILL_W : sss_pkg::CFG_W;
    localparam int unsigned IDX_W  = (CNT_W > 4) ? CNT_W : 4;

    // word address of a position inside a slot
    function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [POS_W-1:0]  pos);
        return ADDR_W'(slot) * ADDR_W'(STACK_DEPTH) + ADDR_W'(pos);
    endfunction

    // configuration and request
    logic [sss_pkg::CFG_W-1:0] r_cap;
    sss_pkg::t_in_item         r_req;

    // stack bookkeeping
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_map [MAX_STACKS];
    logic              r_fill_vld [MAX_STACKS];
    logic [FILL_W-1:0] fill_mem [MAX_STACKS];
    logic [31:0]       val_mem [WORDS];

    // per-request working registers
    logic [FILL_W-1:0] r_fill_q;
    logic              r_fill_q_vld;
    logic [SLOT_W-1:0] r_slot_a;
    logic [SLOT_W-1:0] r_slot_new;
    logic [SLOT_W-1:0] r_pos;
    logic              r_bad;
    logic              r_full;
    logic [31:0]       r_val_q;
    logic              r_rd_hit;
    logic [1:0]        r_status;

    // output register
    logic               r_out_valid;
    sss_pkg::t_out_item r_out;

    // map-stage signals
    logic [CNT_W-1:0]  w_last;
    logic [IDX_W-1:0]  w_pos_wide;
    logic [SLOT_W-1:0] w_pos;
    logic [SLOT_W-1:0] w_slot;
    logic              w_bad;

    // exec-stage signals
    logic [FILL_W-1:0] w_fill;
    logic [CAP_W-1:0]  w_cap;
    logic              w_is_push;
    logic              w_is_take;
    logic              w_open;
    logic              w_val_we;
    logic [ADDR_W-1:0] w_val_waddr;
    logic              w_val_re;
    logic [ADDR_W-1:0] w_val_raddr;
    logic              w_fill_we;
    logic [SLOT_W-1:0] w_fill_wslot;
    logic [FILL_W-1:0] w_fill_wdata;
    logic              w_remove;
    logic              w_inc;
    logic [1:0]        w_status;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= sss_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
    end

    // map stage: logical position, its slot, error checks
    always_comb begin
        w_last = r_count - CNT_W'(1);
        if (r_req.kind == sss_pkg::KIND_POP_AT) begin
            w_pos_wide = IDX_W'(r_req.stack_index);
        end else begin
            w_pos_wide = IDX_W'(w_last);
        end
        // park out-of-range positions on slot zero; only error cases and a push onto an empty set get there
        if (w_pos_wide < IDX_W'(MAX_STACKS)) begin
            w_pos = SLOT_W'(w_pos_wide);
        end else begin
            w_pos = '0;
        end
        // physical slot behind the logical position
        w_slot = r_map[w_pos];
        if (r_req.kind == sss_pkg::KIND_POP_AT) begin
            w_bad = (IDX_W'(r_req.stack_index) >= IDX_W'(r_count));
        end else begin
            w_bad = (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            r_slot_a <= w_slot;
            if (r_count < CNT_W'(MAX_STACKS)) begin
                r_slot_new <= r_map[SLOT_W'(r_count)];
            end else begin
                r_slot_new <= '0;
            end
            r_pos  <= w_pos;
            r_bad  <= w_bad;
            r_full <= (r_count >= CNT_W'(MAX_STACKS));
        end
    end

    // exec stage: decide the update
    always_comb begin
        w_fill = r_fill_q_vld ? r_fill_q : '0;
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (CAP_W'(r_cap) > CAP_W'(STACK_DEPTH)) begin
            w_cap = CAP_W'(STACK_DEPTH);
        end else begin
            w_cap = CAP_W'(r_cap);
        end
        w_is_push = (r_req.kind == sss_pkg::KIND_PUSH);
        w_is_take = (r_req.kind == sss_pkg::KIND_POP) || (r_req.kind == sss_pkg::KIND_POP_AT);
        w_open    = (r_count == '0) || (CAP_W'(w_fill) >= w_cap);

        w_val_we     = 1'b0;
        w_val_waddr  = word_addr(r_slot_a, POS_W'(w_fill));
        w_val_re     = 1'b0;
        w_val_raddr  = word_addr(r_slot_a, POS_W'(w_fill - FILL_W'(1)));
        w_fill_we    = 1'b0;
        w_fill_wslot = r_slot_a;
        w_fill_wdata = w_fill + FILL_W'(1);
        w_remove     = 1'b0;
        w_inc        = 1'b0;
        w_status     = sss_pkg::STAT_OK;

        if (w_is_push) begin
            if (w_open) begin
                if (r_full) begin
                    w_status = sss_pkg::STAT_FULL;
                end else begin
                    // first value of a fresh stack
                    w_val_we     = 1'b1;
                    w_val_waddr  = word_addr(r_slot_new, '0);
                    w_fill_we    = 1'b1;
                    w_fill_wslot = r_slot_new;
                    w_fill_wdata = FILL_W'(1);
                    w_inc        = 1'b1;
                end
            end else begin
                w_val_we  = 1'b1;
                w_fill_we = 1'b1;
            end
        end else if (r_bad) begin
            w_status = sss_pkg::STAT_EMPTY;
        end else begin
            w_val_re = (w_fill != '0);
            if (w_is_take) begin
                w_fill_we = (w_fill != '0);
                w_fill_wdata = w_fill - FILL_W'(1);
                // stack emptied: drop it from the logical order
                w_remove = (w_fill <= FILL_W'(1));
            end
        end
    end

    // fill count memory with reset-cleared valid bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            r_fill_q <= fill_mem[w_slot];
        end
        if (i_cmd.exec && w_fill_we) begin
            fill_mem[w_fill_wslot] <= w_fill_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_q_vld <= 1'b0;
            for (int i = 0; i < int'(MAX_STACKS); i++) begin
                r_fill_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.map) begin
                r_fill_q_vld <= r_fill_vld[w_slot];
            end
            if (i_cmd.exec && w_fill_we) begin
                r_fill_vld[w_fill_wslot] <= 1'b1;
            end
        end
    end

    // value memory, at most one write or one read per request
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_val_we) begin
            val_mem[w_val_waddr] <= r_req.push_value;
        end
        if (i_cmd.exec && w_val_re) begin
            r_val_q <= val_mem[w_val_raddr];
        end
    end

    // stack count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (w_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_remove) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // order map: on removal, entries past the removed one move down,
    // and the freed slot goes to the end of the used range
    for (genvar g = 0; g < int'(MAX_STACKS); g++) begin : g_map
        logic [SLOT_W-1:0] w_next_entry;
        if (g < int'(MAX_STACKS) - 1) begin : g_mid
            assign w_next_entry = r_map[g+1];
        end else begin : g_end
            assign w_next_entry = r_map[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_map[g] <= SLOT_W'(g);
            end else if (i_cmd.exec && w_remove) begin
                if ((SLOT_W'(g) >= r_pos) && (CNT_W'(g) + CNT_W'(1) < r_count)) begin
                    r_map[g] <= w_next_entry;
                end else if (CNT_W'(g) == w_last) begin
                    r_map[g] <= r_slot_a;
                end
            end
        end
    end

    // result bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_rd_hit <= w_val_re;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.result_value  <= r_rd_hit ? r_val_q : '0;
            r_out.status        <= r_status;
            r_out.all_empty     <= (r_count == '0);
            r_out.stacks_in_use <= 5'(r_count);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== hdl/segmented_stack_set_top.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_data  (sss_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (sss_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (stack capacity, 5 bits)
//
// One request at a time: after acceptance it goes through slot lookup and
// fill-count read, update with value memory access, then output load; the next
// request is taken only after that. The fill-count and value memories each give
// registered reads. A new request is taken in the cycle after the result is
// loaded, even while it waits. A stalled output holds the last step until the
// output register frees up.
// Synchronous active-low reset; no clearing pass, ready right after reset.
module segmented_stack_set_top #(
    parameter int unsigned MAX_STACKS  = 16,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sss_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sss_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sss_pkg::CFG_W-1:0] i_cfg_data
);

    sss_pkg::t_cmd w_cmd;
    sss_pkg::t_sts w_sts;

    // capacity writes always land
    assign o_cfg_ready = 1'b1;

    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sss_dpath #(
        .MAX_STACKS  (MAX_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Checks
    `include "segmented_stack_set_top_assert.svh"

    `SSS_ASSERT_NXT(a_one_request, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")
    `SSS_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(w_cmd), "more than one datapath command")
    `SSS_ASSERT_NXT(a_emit_valid, w_cmd.emit, o_out_valid, "result load lost")
    `SSS_ASSERT_IMP(a_err_zero, o_out_valid && (o_out_data.status != sss_pkg::STAT_OK), o_out_data.result_value == 32'sd0, "error result carries a value")

endmodule
